/* rtl/urbe_pkg.sv */
// Shared types, constants and request codes of the UART ring buffer engine.
`timescale 1ns / 1ps
`default_nettype none
package urbe_pkg;

	localparam int RING_DEPTH_DEF   = 256;
	localparam int COUNTER_BITS_DEF = 16;

	localparam int REQ_W       = 2;
	localparam int BYTE_W      = 8;
	localparam int FILL_W      = 8;
	localparam int CNT_OUT_W   = 16;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 96;

	localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_EVENT = 2'd2;

	typedef struct packed {
		logic capture;
		logic exec;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_busy;
	} dp_status_t;

endpackage
`default_nettype wire

/* rtl/urbe_ctrl.sv */
// Controller state machine that sequences capture, ring update and result load.
`timescale 1ns / 1ps
`default_nettype none
module urbe_ctrl (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    s_tvalid,
	output logic                   s_tready,
	input  urbe_pkg::dp_status_t   status,
	output urbe_pkg::ctrl_cmd_t    cmd
);
	import urbe_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_EXEC   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		cmd.capture  = 1'b0;
		cmd.exec     = 1'b0;
		cmd.load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
				if (s_tvalid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_FINISH;
			end
			ST_FINISH: begin
				if (!status.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	a_accept_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> cmd.exec)
		else $error("Accepted transaction was not followed by a ring update.");

	a_exec_then_finish: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> (state_q == ST_FINISH))
		else $error("Ring update was not followed by the result stage.");

	a_load_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> s_tready)
		else $error("Controller did not return to idle after loading a result.");
`endif

endmodule
`default_nettype wire

/* rtl/urbe_datapath.sv */
// Datapath with both ring memories, their pointers, error counters and the result register.
`timescale 1ns / 1ps
`default_nettype none
module urbe_datapath #(
	parameter int RING_DEPTH   = urbe_pkg::RING_DEPTH_DEF,
	parameter int COUNTER_BITS = urbe_pkg::COUNTER_BITS_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  urbe_pkg::ctrl_cmd_t                cmd,
	output urbe_pkg::dp_status_t               status,
	input  wire [urbe_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  wire [urbe_pkg::REQ_W-1:0]          s_tuser,
	output logic                               m_tvalid,
	input  wire                                m_tready,
	output logic [urbe_pkg::OUT_TDATA_W-1:0]   m_tdata
);
	import urbe_pkg::*;

	localparam int PTR_W  = $clog2(RING_DEPTH);
	localparam int DIFF_W = PTR_W + 1;
	localparam int FW     = (DIFF_W > FILL_W) ? DIFF_W : FILL_W;
	localparam int CNT_OW = (COUNTER_BITS > CNT_OUT_W) ? COUNTER_BITS : CNT_OUT_W;

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [CNT_OUT_W-1:0] cnt_low(input logic [COUNTER_BITS-1:0] c);
		logic [CNT_OW-1:0] w;
		w = CNT_OW'(c);
		return w[CNT_OUT_W-1:0];
	endfunction

	logic [REQ_W-1:0]  req_q;
	logic [BYTE_W-1:0] byte_q;
	logic              ovr_q;
	logic              frm_q;
	logic              nse_q;
	logic              rx_rdy_q;
	logic              tx_rdy_q;

	logic [BYTE_W-1:0] tx_mem [RING_DEPTH];
	logic [BYTE_W-1:0] rx_mem [RING_DEPTH];
	logic [BYTE_W-1:0] tx_rdata_q;
	logic [BYTE_W-1:0] rx_rdata_q;

	logic [PTR_W-1:0] tx_wr_q;
	logic [PTR_W-1:0] tx_rd_q;
	logic [PTR_W-1:0] rx_wr_q;
	logic [PTR_W-1:0] rx_rd_q;
	logic             irq_en_q;

	logic [COUNTER_BITS-1:0] ovr_cnt_q;
	logic [COUNTER_BITS-1:0] frm_cnt_q;
	logic [COUNTER_BITS-1:0] nse_cnt_q;
	logic [COUNTER_BITS-1:0] drp_cnt_q;

	logic rd_valid_q;
	logic wr_ok_q;
	logic tx_valid_q;

	logic             is_write;
	logic             is_read;
	logic             is_event;
	logic [PTR_W-1:0] tx_wr_next;
	logic [PTR_W-1:0] tx_rd_next;
	logic [PTR_W-1:0] rx_wr_next;
	logic [PTR_W-1:0] rx_rd_next;
	logic             tx_has_room;
	logic             tx_nonempty;
	logic             rx_has_room;
	logic             rx_nonempty;
	logic             tx_we;
	logic             tx_re;
	logic             rx_we;
	logic             rx_re;
	logic             rx_drop;
	logic             tx_service;
	logic             tx_empty_after;

	logic [DIFF_W-1:0] fill_diff;
	logic [FW-1:0]     fill_wide;
	logic [FILL_W-1:0] fill_sat;

	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic [OUT_TDATA_W-1:0] result;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q    <= s_tuser;
			byte_q   <= s_tdata[7:0];
			ovr_q    <= s_tdata[8];
			frm_q    <= s_tdata[9];
			nse_q    <= s_tdata[10];
			rx_rdy_q <= s_tdata[11];
			tx_rdy_q <= s_tdata[12];
		end
	end

	always_comb begin
		is_write       = cmd.exec && (req_q == REQ_WRITE);
		is_read        = cmd.exec && (req_q == REQ_READ);
		is_event       = cmd.exec && (req_q == REQ_EVENT);
		tx_wr_next     = ring_next(tx_wr_q);
		tx_rd_next     = ring_next(tx_rd_q);
		rx_wr_next     = ring_next(rx_wr_q);
		rx_rd_next     = ring_next(rx_rd_q);
		tx_has_room    = (tx_wr_next != tx_rd_q);
		tx_nonempty    = (tx_wr_q != tx_rd_q);
		rx_has_room    = (rx_wr_next != rx_rd_q);
		rx_nonempty    = (rx_wr_q != rx_rd_q);
		tx_we          = is_write && tx_has_room;
		rx_re          = is_read && rx_nonempty;
		rx_we          = is_event && rx_rdy_q && rx_has_room;
		rx_drop        = is_event && rx_rdy_q && !rx_has_room;
		tx_service     = is_event && tx_rdy_q && irq_en_q;
		tx_re          = tx_service && tx_nonempty;
		tx_empty_after = tx_nonempty ? (tx_rd_next == tx_wr_q) : 1'b1;
	end

	always_ff @(posedge clk) begin
		if (tx_we) begin
			tx_mem[tx_wr_q] <= byte_q;
		end
		if (tx_re) begin
			tx_rdata_q <= tx_mem[tx_rd_q];
		end
	end

	always_ff @(posedge clk) begin
		if (rx_we) begin
			rx_mem[rx_wr_q] <= byte_q;
		end
		if (rx_re) begin
			rx_rdata_q <= rx_mem[rx_rd_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_wr_q    <= '0;
			tx_rd_q    <= '0;
			rx_wr_q    <= '0;
			rx_rd_q    <= '0;
			irq_en_q   <= 1'b0;
			ovr_cnt_q  <= '0;
			frm_cnt_q  <= '0;
			nse_cnt_q  <= '0;
			drp_cnt_q  <= '0;
			rd_valid_q <= 1'b0;
			wr_ok_q    <= 1'b0;
			tx_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			rd_valid_q <= rx_re;
			wr_ok_q    <= tx_we;
			tx_valid_q <= tx_re;
			if (tx_we) begin
				tx_wr_q  <= tx_wr_next;
				irq_en_q <= 1'b1;
			end
			if (rx_re) begin
				rx_rd_q <= rx_rd_next;
			end
			if (rx_we) begin
				rx_wr_q <= rx_wr_next;
			end
			if (tx_re) begin
				tx_rd_q <= tx_rd_next;
			end
			if (tx_service && tx_empty_after) begin
				irq_en_q <= 1'b0;
			end
			if (is_event && ovr_q) begin
				ovr_cnt_q <= ovr_cnt_q + 1'b1;
			end
			if (is_event && frm_q) begin
				frm_cnt_q <= frm_cnt_q + 1'b1;
			end
			if (is_event && nse_q) begin
				nse_cnt_q <= nse_cnt_q + 1'b1;
			end
			if (rx_drop) begin
				drp_cnt_q <= drp_cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		if (rx_wr_q >= rx_rd_q) begin
			fill_diff = {1'b0, rx_wr_q} - {1'b0, rx_rd_q};
		end else begin
			fill_diff = DIFF_W'(RING_DEPTH) + {1'b0, rx_wr_q} - {1'b0, rx_rd_q};
		end
		fill_wide = FW'(fill_diff);
		fill_sat  = (fill_wide > FW'(255)) ? 8'hFF : fill_wide[FILL_W-1:0];
	end

	always_comb begin
		result          = '0;
		result[7:0]     = rd_valid_q ? rx_rdata_q : 8'h00;
		result[8]       = rd_valid_q;
		result[9]       = wr_ok_q;
		result[17:10]   = tx_valid_q ? tx_rdata_q : 8'h00;
		result[18]      = tx_valid_q;
		result[19]      = irq_en_q;
		result[27:20]   = fill_sat;
		result[28]      = (tx_wr_q == tx_rd_q);
		result[44:29]   = cnt_low(ovr_cnt_q);
		result[60:45]   = cnt_low(frm_cnt_q);
		result[76:61]   = cnt_low(nse_cnt_q);
		result[92:77]   = cnt_low(drp_cnt_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			m_tdata_q <= result;
		end
	end

	assign status.out_busy = m_tvalid_q && !m_tready;
	assign m_tvalid        = m_tvalid_q;
	assign m_tdata         = m_tdata_q;

`ifndef SYNTHESIS
	a_load_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> m_tvalid)
		else $error("Loaded result is not presented on the output.");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(tx_wr_q) < RING_DEPTH) && (32'(tx_rd_q) < RING_DEPTH) &&
		(32'(rx_wr_q) < RING_DEPTH) && (32'(rx_rd_q) < RING_DEPTH))
		else $error("Ring pointer left the ring.");

	a_write_fills_tx: assert property (@(posedge clk) disable iff (!arst_n)
		tx_we |=> (tx_wr_q != tx_rd_q) && irq_en_q)
		else $error("Stored transmit byte left the transmit ring empty or disarmed.");
`endif

endmodule
`default_nettype wire

/* rtl/uart_ring_buffer_engine.sv */
// Top level of the UART ring buffer engine: controller and datapath.
`timescale 1ns / 1ps
`default_nettype none
// Each transaction on the input stream is captured, then the rings, pointers and counters are
// updated while the ring memory is read, and then the registered result is loaded into the
// output register. The single read port of each ring memory and its registered read data
// set this sequence of steps. The output register holds a finished result
// while the next transaction is captured and processed; the block only waits when a second
// result is ready before the first has been taken. Both rings keep one slot free, so each
// holds RING_DEPTH-1 bytes. No clearing pass is needed after reset.
module uart_ring_buffer_engine #(
	parameter int RING_DEPTH   = urbe_pkg::RING_DEPTH_DEF,
	parameter int COUNTER_BITS = urbe_pkg::COUNTER_BITS_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	// data_byte[7:0], overrun_flag[8], framing_flag[9], noise_flag[10], rx_ready[11],
	// tx_ready[12], zero fill[15:13].
	input  wire [urbe_pkg::IN_TDATA_W-1:0]    s_tdata,
	// req_type[1:0].
	input  wire [urbe_pkg::REQ_W-1:0]         s_tuser,
	output logic                              m_tvalid,
	input  wire                               m_tready,
	// read_data[7:0], read_valid[8], write_accepted[9], line_tx_byte[17:10],
	// line_tx_valid[18], tx_irq_enabled[19], rx_fill[27:20], tx_empty[28],
	// overrun_count[44:29], framing_count[60:45], noise_count[76:61],
	// dropped_count[92:77], zero fill[95:93].
	output logic [urbe_pkg::OUT_TDATA_W-1:0]  m_tdata
);
	import urbe_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	urbe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	urbe_datapath #(
		.RING_DEPTH   (RING_DEPTH),
		.COUNTER_BITS (COUNTER_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
`default_nettype wire
